// File: hdl/ed_pkg.sv
`default_nettype none

package ed_pkg;

	// transaction commands
	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_QUERY  = 2'd2,
		CMD_EMPTY  = 2'd3
	} cmd_t;

	// width of the reported distance
	localparam int OUT_WIDTH = 16;
	localparam int CH_WIDTH  = 8;

	// request transaction
	typedef struct packed {
		cmd_t                cmd;
		logic [CH_WIDTH-1:0] ch;
		logic                first;
		logic                last;
	} req_t;

	// response transaction
	typedef struct packed {
		logic [OUT_WIDTH-1:0] distance;
		logic                 truncated;
	} rsp_t;

	// broadcast controls shared by every cell of the row
	typedef struct packed {
		logic                restart;
		logic                pat_wr;
		logic [CH_WIDTH-1:0] pat_ch;
		logic [CH_WIDTH-1:0] qch;
	} cell_ctl_t;

	// sequencer states
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_INIT  = 5'b00010,
		ST_ZERO  = 5'b00100,
		ST_SWEEP = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

endpackage

`default_nettype wire

// File: hdl/edit_distance_engine.sv
// timing: pattern clear/append leave the engine idle; a query byte passes INIT (only with
// first set), then ZERO and SWEEP, n being the pattern length, as the update token walks
// the cell row one cell per cycle; a last byte then passes EMIT into the output register
// and waits out any output stall; an empty query goes straight to EMIT
// throughput: one transaction at a time, a new byte is taken only once the last is through
// reset: arst_n clears pattern length, truncation flag, sequencer and output valid
`default_nettype none

module edit_distance_engine #(
	parameter int MAX_PATTERN = 64,
	parameter int DIST_WIDTH  = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire ed_pkg::req_t  req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output ed_pkg::rsp_t       rsp
);

	localparam int NW = $clog2(MAX_PATTERN + 1);
	localparam logic [NW-1:0] N_FULL   = NW'(MAX_PATTERN);
	localparam logic [32:0]   DIST_MAX = (33'd1 << DIST_WIDTH) - 33'd1;
	localparam logic [32:0]   OUT_MAX  = (33'd1 << ed_pkg::OUT_WIDTH) - 33'd1;

	ed_pkg::state_t                state_q;
	logic [NW-1:0]                 n_q;
	logic                          trunc_q;
	logic [ed_pkg::CH_WIDTH-1:0]   qch_q;
	logic                          last_q;
	logic [ed_pkg::OUT_WIDTH-1:0]  res_q;
	ed_pkg::rsp_t                  rsp_q;
	logic                          rsp_valid_q;

	logic                          accept;
	logic                          load;
	ed_pkg::cell_ctl_t             ctl;
	logic [MAX_PATTERN+1:0]        tok_w;
	logic [DIST_WIDTH-1:0]         cost_w [0:MAX_PATTERN+1];
	logic [DIST_WIDTH-1:0]         old_w  [0:MAX_PATTERN+1];
	logic [MAX_PATTERN:0]          done_w;
	logic                          any_done;
	logic [DIST_WIDTH-1:0]         sweep_res;

	function automatic logic [ed_pkg::OUT_WIDTH-1:0] clip_out(input logic [31:0] v);
		logic [32:0] s;
		s = ({1'b0, v} > DIST_MAX) ? DIST_MAX : {1'b0, v};
		if (s > OUT_MAX) begin
			s = OUT_MAX;
		end
		return s[ed_pkg::OUT_WIDTH-1:0];
	endfunction

	assign req_ready = (state_q == ed_pkg::ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign load      = (state_q == ed_pkg::ST_EMIT) && (!rsp_valid_q || rsp_ready);

	// broadcast controls
	always_comb begin
		ctl.restart = (state_q == ed_pkg::ST_INIT);
		ctl.pat_wr  = accept && (req.cmd == ed_pkg::CMD_APPEND) && (n_q != N_FULL);
		ctl.pat_ch  = req.ch;
		ctl.qch     = qch_q;
	end

	// left edge of the row: cell 0 only ever increments
	assign tok_w[0]  = (state_q == ed_pkg::ST_ZERO);
	assign cost_w[0] = '1;
	assign old_w[0]  = '1;

	// row of cells, cell j holds row entry j and pattern byte j-1
	for (genvar j = 0; j <= MAX_PATTERN; j++) begin : g_cell
		ed_cell #(
			.IDX        (j),
			.DIST_WIDTH (DIST_WIDTH),
			.NW         (NW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.n        (n_q),
			.tok_in   (tok_w[j]),
			.left_new (cost_w[j]),
			.left_old (old_w[j]),
			.tok_out  (tok_w[j+1]),
			.cost_out (cost_w[j+1]),
			.old_out  (old_w[j+1]),
			.done     (done_w[j])
		);
	end

	// pick the entry of the cell where the wavefront ended
	always_comb begin
		sweep_res = '0;
		for (int j = 0; j <= MAX_PATTERN; j++) begin
			sweep_res = sweep_res | (done_w[j] ? cost_w[j+1] : '0);
		end
	end
	assign any_done = |done_w;

	// sequencer, pattern length and truncation flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ed_pkg::ST_IDLE;
			n_q     <= '0;
			trunc_q <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			case (state_q)
				ed_pkg::ST_IDLE: begin
					if (accept) begin
						case (req.cmd)
							ed_pkg::CMD_CLEAR: begin
								n_q     <= '0;
								trunc_q <= 1'b0;
							end
							ed_pkg::CMD_APPEND: begin
								if (n_q != N_FULL) begin
									n_q <= n_q + NW'(1);
								end else begin
									trunc_q <= 1'b1;
								end
							end
							ed_pkg::CMD_QUERY: begin
								last_q  <= req.last;
								state_q <= req.first ? ed_pkg::ST_INIT : ed_pkg::ST_ZERO;
							end
							default: begin
								state_q <= ed_pkg::ST_EMIT;
							end
						endcase
					end
				end
				ed_pkg::ST_INIT: begin
					state_q <= ed_pkg::ST_ZERO;
				end
				ed_pkg::ST_ZERO: begin
					state_q <= ed_pkg::ST_SWEEP;
				end
				ed_pkg::ST_SWEEP: begin
					if (any_done) begin
						state_q <= last_q ? ed_pkg::ST_EMIT : ed_pkg::ST_IDLE;
					end
				end
				ed_pkg::ST_EMIT: begin
					if (load) begin
						state_q <= ed_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= ed_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// query byte and pending result
	always_ff @(posedge clk) begin
		if (accept && (req.cmd == ed_pkg::CMD_QUERY)) begin
			qch_q <= req.ch;
		end
		if (accept && (req.cmd == ed_pkg::CMD_EMPTY)) begin
			res_q <= clip_out(32'(n_q));
		end else if ((state_q == ed_pkg::ST_SWEEP) && any_done) begin
			res_q <= clip_out(32'(sweep_res));
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q.distance  <= res_q;
			rsp_q.truncated <= trunc_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// File: hdl/ed_cell.sv
`default_nettype none

module ed_cell #(
	parameter int IDX         = 0,
	parameter int DIST_WIDTH  = 16,
	parameter int NW          = 7
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire ed_pkg::cell_ctl_t     ctl,
	input  wire logic [NW-1:0]         n,
	input  wire logic                  tok_in,
	input  wire logic [DIST_WIDTH-1:0] left_new,
	input  wire logic [DIST_WIDTH-1:0] left_old,
	output logic                       tok_out,
	output logic [DIST_WIDTH-1:0]      cost_out,
	output logic [DIST_WIDTH-1:0]      old_out,
	output logic                       done
);

	localparam logic [63:0] DIST_MAX = (64'd1 << DIST_WIDTH) - 64'd1;
	localparam logic [63:0] IDX_W    = 64'(IDX);
	localparam logic [DIST_WIDTH-1:0] INIT_COST =
		DIST_WIDTH'((IDX_W > DIST_MAX) ? DIST_MAX : IDX_W);
	localparam bit HAS_PAT = (IDX != 0);
	localparam logic [NW-1:0] PAT_SLOT = HAS_PAT ? NW'(IDX - 1) : '0;
	localparam logic [NW-1:0] MY_IDX   = NW'(IDX);

	logic [ed_pkg::CH_WIDTH-1:0] pat_q;
	logic [DIST_WIDTH-1:0]       cost_q;
	logic [DIST_WIDTH-1:0]       old_q;
	logic                        tok_q;
	logic                        done_q;
	logic [DIST_WIDTH-1:0]       up_inc;
	logic [DIST_WIDTH-1:0]       left_inc;
	logic [DIST_WIDTH-1:0]       sub_cost;
	logic [DIST_WIDTH-1:0]       min_a;
	logic [DIST_WIDTH-1:0]       cost_nxt;
	logic                        is_end;

	function automatic logic [DIST_WIDTH-1:0] sat_inc(input logic [DIST_WIDTH-1:0] v);
		return (&v) ? v : v + DIST_WIDTH'(1);
	endfunction

	assign is_end = (n == MY_IDX);

	// pattern byte slot; cell 0 keeps a dummy byte, its left inputs are all ones
	always_ff @(posedge clk) begin
		if (ctl.pat_wr && (n == PAT_SLOT)) begin
			pat_q <= ctl.pat_ch;
		end
	end

	// recurrence: min of insert, delete and substitute
	always_comb begin
		up_inc   = sat_inc(cost_q);
		left_inc = sat_inc(left_new);
		sub_cost = (ctl.qch == pat_q) ? left_old : sat_inc(left_old);
		min_a    = (up_inc < left_inc) ? up_inc : left_inc;
		cost_nxt = (sub_cost < min_a) ? sub_cost : min_a;
	end

	// row entry and the old value handed to the right neighbor
	// only entries 0..n restart, the rest keep their last value
	always_ff @(posedge clk) begin
		if (ctl.restart && (MY_IDX <= n)) begin
			cost_q <= INIT_COST;
		end else if (tok_in) begin
			cost_q <= cost_nxt;
			old_q  <= cost_q;
		end
	end

	// wavefront token
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			tok_q  <= tok_in && !is_end;
			done_q <= tok_in && is_end;
		end
	end

	assign tok_out  = tok_q;
	assign cost_out = cost_q;
	assign old_out  = old_q;
	assign done     = done_q;

endmodule

`default_nettype wire

// File: hdl/ed_checker.sv
`default_nettype none

module ed_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         req_valid,
	input wire logic         req_ready,
	input wire ed_pkg::req_t req,
	input wire logic         rsp_valid,
	input wire logic         rsp_ready,
	input wire ed_pkg::rsp_t rsp
);

	logic req_acc;

	assign req_acc = req_valid && req_ready;

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// pattern commands leave the engine ready in the next cycle
	a_pat_fast: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && (req.cmd == ed_pkg::CMD_CLEAR || req.cmd == ed_pkg::CMD_APPEND)
		|=> req_ready)
		else $error("pattern command did not complete in one cycle");

	// query and empty-query transactions occupy the engine
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && (req.cmd == ed_pkg::CMD_QUERY || req.cmd == ed_pkg::CMD_EMPTY)
		|=> !req_ready)
		else $error("engine ready right after a query transaction");

	// empty query answers through EMIT and the output register when the output is free
	a_empty_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && (req.cmd == ed_pkg::CMD_EMPTY) && !rsp_valid |-> ##2 rsp_valid)
		else $error("empty query response missing");

endmodule

bind edit_distance_engine ed_checker u_ed_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

`default_nettype wire
